// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file gvt_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// A condition that must hold in the cycle after a trigger.
`define ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

`endif

// ===== hdl/gvt_pkg.sv =====
// ----------------------------------------------------------------------------
// gvt_pkg: shared definitions of the VRAM transfer unit
// Job codes, transfer modes, command opcodes and packet length tables.
// ----------------------------------------------------------------------------
package gvt_pkg;

    // Default configuration
    localparam int STORE_COLUMNS_DEF    = 1024;
    localparam int STORE_ROWS_DEF       = 512;
    localparam int MAX_PACKET_WORDS_DEF = 12;

    // Transfer modes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Job kinds handed from the front to the back
    localparam logic [1:0] JOB_NONE  = 2'd0;
    localparam logic [1:0] JOB_WRITE = 2'd1;
    localparam logic [1:0] JOB_READ  = 2'd2;

    // Command opcodes
    localparam logic [7:0] OP_HOST_TO_STORE = 8'ha0;
    localparam logic [7:0] OP_STORE_TO_HOST = 8'hc0;
    localparam logic [7:0] OP_CLEAR_CACHE   = 8'h02;
    localparam logic [7:0] OP_COPY_RECT     = 8'h80;

    typedef struct packed {
        logic [1:0] kind;
        logic       two_px;
        logic [1:0] mode;
    } job_ctrl_t;

    typedef struct packed {
        logic [9:0] sx;
        logic [8:0] sy;
        logic       done;
    } step_t;

    typedef logic [3:0] len_table_t [8];

    localparam len_table_t LEN_POLYS = '{4'd4, 4'd7, 4'd5, 4'd9, 4'd6, 4'd9, 4'd8, 4'd12};
    localparam len_table_t LEN_RECTS = '{4'd3, 4'd4, 4'd2, 4'd3, 4'd2, 4'd3, 4'd2, 4'd3};

    // Packet length in words for an opcode; zero means no packet opens.
    function automatic logic [4:0] packet_words(logic [7:0] op);
        logic [4:0] len;
        len = 5'd0;
        if (op == OP_CLEAR_CACHE) len = 5'd3;
        else if (op[7:5] == 3'b001) len = {1'b0, LEN_POLYS[op[4:2]]};
        else if (op[7:5] == 3'b011) len = {1'b0, LEN_RECTS[op[4:2]]};
        else if (op == OP_COPY_RECT) len = 5'd4;
        else if (op == OP_HOST_TO_STORE || op == OP_STORE_TO_HOST) len = 5'd3;
        return len;
    endfunction

    // Advance the rectangle walk by one pixel.
    function automatic step_t advance(step_t s, logic [10:0] w, logic [9:0] h);
        step_t      r;
        logic [10:0] nx;
        logic [9:0]  ny;
        nx = {1'b0, s.sx} + 11'd1;
        ny = {1'b0, s.sy} + 10'd1;
        r = s;
        r.done = 1'b0;
        if (nx >= w)
        begin
            r.sx = 10'd0;
            if (ny >= h)
            begin
                r.sy   = 9'd0;
                r.done = 1'b1;
            end
            else
            begin
                r.sy = ny[8:0];
            end
        end
        else
        begin
            r.sx = nx[9:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/gpu_packet_vram_transfer_unit.sv =====
// Path: an accepted request passes the job queue, the registered frame store port and
// result flag of the back, then the result queue; command words and idle reads take one
// store step each, pixel words one access per 16-bit pixel on the single-port frame store.
// Reset: asynchronous, clears framing, rectangle, mode and queues; the frame store
// is not initialized and needs no clearing pass.
// ----------------------------------------------------------------------------
// gpu_packet_vram_transfer_unit: command port with VRAM rectangle transfer
// Front frames commands and walks rectangles, back accesses the frame store.
// ----------------------------------------------------------------------------
module gpu_packet_vram_transfer_unit #(
    parameter int STORE_COLUMNS    = gvt_pkg::STORE_COLUMNS_DEF,
    parameter int STORE_ROWS       = gvt_pkg::STORE_ROWS_DEF,
    parameter int MAX_PACKET_WORDS = gvt_pkg::MAX_PACKET_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        opcode,
    input  logic [31:0] bus_word,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] read_word,
    output logic [1:0]  transfer_mode
);
    localparam int CW        = $clog2(STORE_COLUMNS);
    localparam int RW        = $clog2(STORE_ROWS);
    localparam int CTW       = $bits(gvt_pkg::job_ctrl_t);
    localparam int JW        = CTW + 2 * (CW + RW) + 32;
    localparam int OUT_DEPTH = 4;

    logic               accept;
    gvt_pkg::job_ctrl_t f_ctrl, b_ctrl;
    logic [CW-1:0]      f_col0, f_col1, b_col0, b_col1;
    logic [RW-1:0]      f_row0, f_row1, b_row0, b_row1;
    logic [31:0]        b_data;
    logic [JW-1:0]      job_in, job_out;
    logic               job_empty, job_pop;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
    logic               res_push;
    logic [33:0]        res_data, res_out;

    assign accept = push && !full;

    gvt_front #(
        .STORE_COLUMNS    (STORE_COLUMNS),
        .STORE_ROWS       (STORE_ROWS),
        .MAX_PACKET_WORDS (MAX_PACKET_WORDS),
        .CW               (CW),
        .RW               (RW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .opcode   (opcode),
        .bus_word (bus_word),
        .job_ctrl (f_ctrl),
        .col0     (f_col0),
        .row0     (f_row0),
        .col1     (f_col1),
        .row1     (f_row1)
    );

    // Job queue between front and back.
    assign job_in = {f_ctrl, f_col0, f_row0, f_col1, f_row1, bus_word};
    assign {b_ctrl, b_col0, b_row0, b_col1, b_row1, b_data} = job_out;

    gvt_fifo #(.W(JW), .DEPTH(2)) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata (job_in),
        .full  (full),
        .pop   (job_pop),
        .rdata (job_out),
        .empty (job_empty),
        .count ()
    );

    gvt_back #(
        .STORE_COLUMNS (STORE_COLUMNS),
        .STORE_ROWS    (STORE_ROWS),
        .CW            (CW),
        .RW            (RW),
        .OUT_DEPTH     (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .job_ctrl  (b_ctrl),
        .col0      (b_col0),
        .row0      (b_row0),
        .col1      (b_col1),
        .row1      (b_row1),
        .job_data  (b_data),
        .out_count (out_count),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    // Result queue toward the host.
    gvt_fifo #(.W(34), .DEPTH(OUT_DEPTH)) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty),
        .count (out_count)
    );

    assign transfer_mode = res_out[33:32];
    assign read_word     = res_out[31:0];

endmodule

// ===== hdl/gvt_fifo.sv =====
// ----------------------------------------------------------------------------
// gvt_fifo: small register queue
// Holds jobs and results between the parts of the transfer unit.
// ----------------------------------------------------------------------------
module gvt_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [W-1:0]               wdata,
    output logic                       full,
    input  logic                       pop,
    output logic [W-1:0]               rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [W-1:0]    entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    // Pointer and count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNTW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNTW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// ===== hdl/gvt_front.sv =====
// ----------------------------------------------------------------------------
// gvt_front: command framing and transfer walk
// Classifies each port access, frames command packets and computes the
// frame store coordinates of the pixels that an access touches.
// ----------------------------------------------------------------------------
module gvt_front #(
    parameter int STORE_COLUMNS    = gvt_pkg::STORE_COLUMNS_DEF,
    parameter int STORE_ROWS       = gvt_pkg::STORE_ROWS_DEF,
    parameter int MAX_PACKET_WORDS = gvt_pkg::MAX_PACKET_WORDS_DEF,
    parameter int CW               = $clog2(STORE_COLUMNS),
    parameter int RW               = $clog2(STORE_ROWS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              opcode,
    input  logic [31:0]       bus_word,
    output gvt_pkg::job_ctrl_t job_ctrl,
    output logic [CW-1:0]     col0,
    output logic [RW-1:0]     row0,
    output logic [CW-1:0]     col1,
    output logic [RW-1:0]     row1
);
    localparam logic [4:0] MAX_LEN = 5'(MAX_PACKET_WORDS);

    logic [1:0]  mode_reg, mode_next;
    logic [7:0]  pkt_op_reg, pkt_op_next;
    logic [3:0]  pkt_cnt_reg, pkt_cnt_next;
    logic [9:0]  rect_x_reg, rect_x_next;
    logic [8:0]  rect_y_reg, rect_y_next;
    logic [10:0] rect_w_reg, rect_w_next;
    logic [9:0]  rect_h_reg, rect_h_next;
    logic [9:0]  step_x_reg, step_x_next;
    logic [8:0]  step_y_reg, step_y_next;
    logic [9:0]  pend_x_reg, pend_x_next;
    logic [8:0]  pend_y_reg, pend_y_next;

    gvt_pkg::step_t cur, adv1, adv2;
    logic [9:0]  px0, px1;
    logic [8:0]  py0, py1;
    logic [7:0]  op;
    logic [4:0]  len;
    logic [3:0]  cnt_inc;

    // Column and row reduction by repeated constant compares.
    function automatic logic [CW-1:0] col_of(logic [9:0] x);
        logic [CW-1:0] r;
        r = CW'(x);
        for (int k = 1; k < 16; k++)
            if (32'(x) >= k * STORE_COLUMNS)
                r = CW'(32'(x) - k * STORE_COLUMNS);
        return r;
    endfunction

    function automatic logic [RW-1:0] row_of(logic [8:0] y);
        logic [RW-1:0] r;
        r = RW'(y);
        for (int k = 1; k < 8; k++)
            if (32'(y) >= k * STORE_ROWS)
                r = RW'(32'(y) - k * STORE_ROWS);
        return r;
    endfunction

    // Pixel positions of the two halves of this access.
    always_comb
    begin
        cur.sx   = step_x_reg;
        cur.sy   = step_y_reg;
        cur.done = 1'b0;
        adv1     = gvt_pkg::advance(cur, rect_w_reg, rect_h_reg);
        adv2     = gvt_pkg::advance(adv1, rect_w_reg, rect_h_reg);
        px0      = rect_x_reg + step_x_reg;
        py0      = rect_y_reg + step_y_reg;
        px1      = rect_x_reg + adv1.sx;
        py1      = rect_y_reg + adv1.sy;
    end

    assign col0 = col_of(px0);
    assign row0 = row_of(py0);
    assign col1 = col_of(px1);
    assign row1 = row_of(py1);

    assign op      = (pkt_cnt_reg == 4'd0) ? bus_word[31:24] : pkt_op_reg;
    assign len     = (gvt_pkg::packet_words(op) > MAX_LEN) ? MAX_LEN
                                                           : gvt_pkg::packet_words(op);
    assign cnt_inc = pkt_cnt_reg + 4'd1;

    // Next state and job classification for one access.
    always_comb
    begin
        mode_next    = mode_reg;
        pkt_op_next  = pkt_op_reg;
        pkt_cnt_next = pkt_cnt_reg;
        rect_x_next  = rect_x_reg;
        rect_y_next  = rect_y_reg;
        rect_w_next  = rect_w_reg;
        rect_h_next  = rect_h_reg;
        step_x_next  = step_x_reg;
        step_y_next  = step_y_reg;
        pend_x_next  = pend_x_reg;
        pend_y_next  = pend_y_reg;
        job_ctrl.kind   = gvt_pkg::JOB_NONE;
        job_ctrl.two_px = !adv1.done;
        if ((opcode && mode_reg == gvt_pkg::MODE_READ) ||
            (!opcode && mode_reg == gvt_pkg::MODE_WRITE))
        begin
            job_ctrl.kind = opcode ? gvt_pkg::JOB_READ : gvt_pkg::JOB_WRITE;
            step_x_next   = adv1.done ? adv1.sx : adv2.sx;
            step_y_next   = adv1.done ? adv1.sy : adv2.sy;
            if (adv1.done || adv2.done)
                mode_next = gvt_pkg::MODE_IDLE;
        end
        else if (!opcode)
        begin
            pkt_op_next = op;
            if (len != 5'd0)
            begin
                if (pkt_cnt_reg == 4'd1)
                begin
                    pend_x_next = bus_word[9:0];
                    pend_y_next = bus_word[24:16];
                end
                pkt_cnt_next = cnt_inc;
                if ({1'b0, cnt_inc} >= len)
                begin
                    pkt_cnt_next = 4'd0;
                    if (op == gvt_pkg::OP_HOST_TO_STORE || op == gvt_pkg::OP_STORE_TO_HOST)
                    begin
                        rect_x_next = pend_x_reg;
                        rect_y_next = pend_y_reg;
                        rect_w_next = {1'b0, bus_word[9:0] - 10'd1} + 11'd1;
                        rect_h_next = {1'b0, bus_word[24:16] - 9'd1} + 10'd1;
                        step_x_next = 10'd0;
                        step_y_next = 9'd0;
                        mode_next   = (op == gvt_pkg::OP_HOST_TO_STORE) ?
                                      gvt_pkg::MODE_WRITE : gvt_pkg::MODE_READ;
                    end
                end
            end
        end
        job_ctrl.mode = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= gvt_pkg::MODE_IDLE;
            pkt_op_reg  <= 8'd0;
            pkt_cnt_reg <= 4'd0;
            rect_x_reg  <= 10'd0;
            rect_y_reg  <= 9'd0;
            rect_w_reg  <= 11'd1;
            rect_h_reg  <= 10'd1;
            step_x_reg  <= 10'd0;
            step_y_reg  <= 9'd0;
            pend_x_reg  <= 10'd0;
            pend_y_reg  <= 9'd0;
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            pkt_op_reg  <= pkt_op_next;
            pkt_cnt_reg <= pkt_cnt_next;
            rect_x_reg  <= rect_x_next;
            rect_y_reg  <= rect_y_next;
            rect_w_reg  <= rect_w_next;
            rect_h_reg  <= rect_h_next;
            step_x_reg  <= step_x_next;
            step_y_reg  <= step_y_next;
            pend_x_reg  <= pend_x_next;
            pend_y_reg  <= pend_y_next;
        end
    end

endmodule

// ===== hdl/gvt_back.sv =====
// ----------------------------------------------------------------------------
// gvt_back: frame store access engine
// Carries out queued jobs on the single-port frame store, one pixel per
// cycle while the result queue has room, and assembles the result word of each request.
// ----------------------------------------------------------------------------
module gvt_back #(
    parameter int STORE_COLUMNS = gvt_pkg::STORE_COLUMNS_DEF,
    parameter int STORE_ROWS    = gvt_pkg::STORE_ROWS_DEF,
    parameter int CW            = $clog2(STORE_COLUMNS),
    parameter int RW            = $clog2(STORE_ROWS),
    parameter int OUT_DEPTH     = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           job_empty,
    output logic                           job_pop,
    input  gvt_pkg::job_ctrl_t             job_ctrl,
    input  logic [CW-1:0]                  col0,
    input  logic [RW-1:0]                  row0,
    input  logic [CW-1:0]                  col1,
    input  logic [RW-1:0]                  row1,
    input  logic [31:0]                    job_data,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
    output logic                           res_push,
    output logic [33:0]                    res_data
);
    localparam int AW   = $clog2(STORE_COLUMNS * STORE_ROWS);
    localparam int CNTW = $clog2(OUT_DEPTH + 1);

    logic [15:0] store [STORE_COLUMNS * STORE_ROWS];

    logic               sub_reg, sub_next;
    logic               done_reg, done_next;
    gvt_pkg::job_ctrl_t done_ctrl_reg;
    logic [15:0]        rdata_reg, pix0_reg;
    logic               room, active, is_mem;
    logic [CW-1:0]      col;
    logic [RW-1:0]      row;
    logic [AW-1:0]      addr;
    logic [15:0]        wdata;
    logic               mem_we, mem_re;

    assign room   = ({1'b0, out_count} + (CNTW + 1)'(done_reg)) < (CNTW + 1)'(OUT_DEPTH);
    assign active = !job_empty && (sub_reg || room);
    assign is_mem = (job_ctrl.kind != gvt_pkg::JOB_NONE);

    // Pixel address of the current step.
    assign col   = sub_reg ? col1 : col0;
    assign row   = sub_reg ? row1 : row0;
    assign addr  = AW'(row) * AW'(STORE_COLUMNS) + AW'(col);
    assign wdata = sub_reg ? job_data[31:16] : job_data[15:0];

    assign mem_we = active && (job_ctrl.kind == gvt_pkg::JOB_WRITE);
    assign mem_re = active && (job_ctrl.kind == gvt_pkg::JOB_READ);

    // Step sequencing: a second step for a two-pixel job.
    always_comb
    begin
        sub_next  = sub_reg;
        done_next = 1'b0;
        job_pop   = 1'b0;
        if (active)
        begin
            if (sub_reg || !is_mem || !job_ctrl.two_px)
            begin
                job_pop   = 1'b1;
                done_next = 1'b1;
                sub_next  = 1'b0;
            end
            else
            begin
                sub_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            sub_reg  <= sub_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
            done_ctrl_reg <= job_ctrl;
        if (active && sub_reg)
            pix0_reg <= rdata_reg;
    end

    // Frame store port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store[addr] <= wdata;
        else if (mem_re)
            rdata_reg <= store[addr];
    end

    // Result word, in the cycle after the last access.
    always_comb
    begin
        res_push = done_reg;
        res_data = {done_ctrl_reg.mode, 32'd0};
        if (done_ctrl_reg.kind == gvt_pkg::JOB_READ)
            res_data[31:0] = done_ctrl_reg.two_px ? {rdata_reg, pix0_reg} : {rdata_reg, 16'd0};
    end

endmodule

// ===== hdl/gvt_checker.sv =====
// ----------------------------------------------------------------------------
// gvt_checker: port-level checks of the transfer unit
// Watches the request and result queues of the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gvt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] read_word,
    input logic [1:0]  transfer_mode
);
    logic seen_reg;
    logic write_mode;

    // Host-to-store responses never carry pixel data.
    assign write_mode = (transfer_mode == gvt_pkg::MODE_WRITE);

    // Set once the first request has been accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= 1'b0;
        else if (push && !full)
            seen_reg <= 1'b1;
    end

    `ASSERT_ALWAYS(a_mode_legal, clk, rst_n, empty || transfer_mode <= gvt_pkg::MODE_READ)
    `ASSERT_ALWAYS(a_write_mode_zero, clk, rst_n, empty || !write_mode || read_word == 32'd0)
    `ASSERT_ALWAYS(a_no_result_unasked, clk, rst_n, seen_reg || empty)
    `ASSERT_NEXT(a_result_holds, clk, rst_n, !empty && !pop, !empty && $stable(read_word))

endmodule

bind gpu_packet_vram_transfer_unit gvt_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .read_word     (read_word),
    .transfer_mode (transfer_mode)
);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the command port and VRAM rectangle transfer
// Command packets, host-to-store uploads and store-to-host readbacks are
// driven through the request queue; a built-in predictor checks each response.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        logic        rd;
        logic [31:0] word;
        logic        drain;
    } request_t;

    typedef struct {
        logic [31:0] pixels;
        logic [1:0]  mode;
    } response_t;

    typedef struct {
        logic [31:0] origin;
        logic [31:0] size;
        int          words;
    } rect_rec_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        opcode;
    logic [31:0] bus_word;
    logic        empty;
    logic        pop;
    logic [31:0] read_word;
    logic [1:0]  transfer_mode;

    request_t    pending_q[$];
    response_t   expected_q[$];
    rect_rec_t   uploaded[$];
    int          errors = 0;
    int          cycles = 0;
    int          tx_gap = 0;
    int          rx_gap = 0;
    int          accepted = 0;
    bit          quiet = 0;

    // Predictor state
    logic [15:0] vram [int];
    logic [1:0]  p_mode;
    logic [7:0]  p_op;
    logic [3:0]  p_count;
    logic [9:0]  p_rx, p_sx, p_px;
    logic [8:0]  p_ry, p_sy, p_py;
    logic [10:0] p_rw;
    logic [9:0]  p_rh;

    gpu_packet_vram_transfer_unit u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .opcode(opcode),
        .bus_word(bus_word), .empty(empty), .pop(pop), .read_word(read_word),
        .transfer_mode(transfer_mode)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Words per packet for a given opcode byte; zero means the word is dropped.
    function automatic int words_for_op(logic [7:0] op);
        logic [3:0] polys [8] = '{4'd4, 4'd7, 4'd5, 4'd9, 4'd6, 4'd9, 4'd8, 4'd12};
        logic [3:0] rects [8] = '{4'd3, 4'd4, 4'd2, 4'd3, 4'd2, 4'd3, 4'd2, 4'd3};
        if (op == gvt_pkg::OP_CLEAR_CACHE) return 3;
        if (op[7:5] == 3'b001) return polys[op[4:2]];
        if (op[7:5] == 3'b011) return rects[op[4:2]];
        if (op == gvt_pkg::OP_COPY_RECT) return 4;
        if (op == gvt_pkg::OP_HOST_TO_STORE || op == gvt_pkg::OP_STORE_TO_HOST) return 3;
        return 0;
    endfunction

    function automatic int pixel_addr();
        logic [9:0] x;
        logic [8:0] y;
        x = p_rx + p_sx;
        y = p_ry + p_sy;
        return int'(y) * 1024 + int'(x);
    endfunction

    // Step the rectangle walk; returns 1 after the last pixel.
    function automatic bit walk_pixel();
        if ({1'b0, p_sx} + 11'd1 >= p_rw)
        begin
            p_sx = '0;
            if ({1'b0, p_sy} + 10'd1 >= p_rh)
            begin
                p_sy   = '0;
                p_mode = gvt_pkg::MODE_IDLE;
                return 1'b1;
            end
            p_sy = p_sy + 9'd1;
        end
        else
        begin
            p_sx = p_sx + 10'd1;
        end
        return 1'b0;
    endfunction

    function automatic void frame_command(logic [31:0] w);
        int len;
        if (p_count == 0) p_op = w[31:24];
        len = words_for_op(p_op);
        if (len == 0) return;
        if (p_count == 1)
        begin
            p_px = w[9:0];
            p_py = w[24:16];
        end
        p_count = p_count + 4'd1;
        if (p_count < len) return;
        p_count = '0;
        if (p_op == gvt_pkg::OP_HOST_TO_STORE || p_op == gvt_pkg::OP_STORE_TO_HOST)
        begin
            p_rx   = p_px;
            p_ry   = p_py;
            p_rw   = {1'b0, w[9:0] - 10'd1} + 11'd1;
            p_rh   = {1'b0, w[24:16] - 9'd1} + 10'd1;
            p_sx   = '0;
            p_sy   = '0;
            p_mode = (p_op == gvt_pkg::OP_HOST_TO_STORE) ? gvt_pkg::MODE_WRITE
                                                         : gvt_pkg::MODE_READ;
        end
    endfunction

    // Expected response of one accepted request.
    function automatic response_t predict_access(logic rd, logic [31:0] w);
        response_t r;
        r.pixels = '0;
        if (rd)
        begin
            if (p_mode == gvt_pkg::MODE_READ)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    r.pixels = {vram[pixel_addr()], r.pixels[31:16]};
                    if (walk_pixel()) break;
                end
            end
        end
        else if (p_mode == gvt_pkg::MODE_WRITE)
        begin
            for (int k = 0; k < 2; k++)
            begin
                vram[pixel_addr()] = w[15:0];
                w = w >> 16;
                if (walk_pixel()) break;
            end
        end
        else
        begin
            frame_command(w);
        end
        r.mode = p_mode;
        return r;
    endfunction

    // Idle lengths: mostly short, a few long, none at all in quiet stretches.
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        logic nxt_push;
        if (!rst_n)
        begin
            push     <= 1'b0;
            opcode   <= 1'b0;
            bus_word <= '0;
        end
        else
        begin
            nxt_push = push;
            if (push && !full)
            begin
                expected_q.push_back(predict_access(opcode, bus_word));
                accepted++;
                if (accepted % 97 == 0) quiet = ~quiet;
                nxt_push = 1'b0;
                tx_gap   = pick_gap();
            end
            if (!nxt_push)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                end
                else if (pending_q.size() > 0 &&
                         (!pending_q[0].drain || expected_q.size() == 0))
                begin
                    opcode   <= pending_q[0].rd;
                    bus_word <= pending_q[0].word;
                    void'(pending_q.pop_front());
                    nxt_push = 1'b1;
                end
            end
            push <= nxt_push;
        end
    end

    // Response monitor.
    always @(posedge clk or negedge rst_n)
    begin
        response_t e;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_q.size() == 0)
                begin
                    report("unexpected response", read_word, '0);
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (read_word !== e.pixels) report("read_word", read_word, e.pixels);
                    if (transfer_mode !== e.mode)
                        report("transfer_mode", transfer_mode, e.mode);
                end
                rx_gap = pick_gap();
            end
            if (rx_gap > 0)
            begin
                rx_gap--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 600000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic add_req(logic rd, logic [31:0] w, logic drain = 1'b0);
        request_t q;
        q.rd    = rd;
        q.word  = w;
        q.drain = drain;
        pending_q.push_back(q);
    endtask

    // A complete packet that leaves the rectangle engine alone.
    task automatic add_noise_packet(logic [7:0] op);
        int len;
        len = words_for_op(op);
        add_req(1'b0, {op, 24'($urandom)});
        for (int i = 1; i < len; i++) add_req(1'b0, $urandom);
    endtask

    function automatic logic [7:0] noise_op();
        logic [7:0] op;
        case ($urandom_range(0, 4))
            0: op = gvt_pkg::OP_CLEAR_CACHE;
            1: op = 8'h20 | 8'($urandom_range(0, 31));
            2: op = 8'h60 | 8'($urandom_range(0, 31));
            3: op = gvt_pkg::OP_COPY_RECT;
            default:
            begin
                op = 8'($urandom);
                while (op == gvt_pkg::OP_HOST_TO_STORE || op == gvt_pkg::OP_STORE_TO_HOST)
                    op = 8'($urandom);
            end
        endcase
        return op;
    endfunction

    function automatic rect_rec_t make_rect(int x, int y, int w, int h);
        rect_rec_t r;
        r.origin = {7'($urandom), 9'(y), 6'($urandom), 10'(x)};
        r.size   = {7'($urandom), 9'(h % 512), 6'($urandom), 10'(w % 1024)};
        r.words  = (w * h + 1) / 2;
        return r;
    endfunction

    // Upload a rectangle, with a few ignored reads mixed in.
    task automatic add_upload(rect_rec_t r, logic drain = 1'b0);
        add_req(1'b0, {gvt_pkg::OP_HOST_TO_STORE, 24'($urandom)}, drain);
        add_req(1'b0, r.origin);
        add_req(1'b0, r.size);
        for (int i = 0; i < r.words; i++)
        begin
            if ($urandom_range(0, 9) == 0) add_req(1'b1, $urandom);
            add_req(1'b0, $urandom);
        end
        uploaded.push_back(r);
    endtask

    // Read back a stored rectangle; command packets may be mixed in, and the
    // transfer may be replaced part way by a new readback.
    task automatic add_readback(rect_rec_t r, logic drain = 1'b0);
        rect_rec_t n;
        add_req(1'b0, {gvt_pkg::OP_STORE_TO_HOST, 24'($urandom)}, drain);
        add_req(1'b0, r.origin);
        add_req(1'b0, r.size);
        for (int i = 0; i < r.words; i++)
        begin
            if ($urandom_range(0, 9) == 0) add_noise_packet(noise_op());
            if (r.words > 1 && $urandom_range(0, 19) == 0)
            begin
                n = uploaded[$urandom_range(0, uploaded.size() - 1)];
                add_readback(n);
                return;
            end
            add_req(1'b1, $urandom);
        end
    endtask

    initial
    begin
        rect_rec_t r;
        int c;
        rst_n = 1'b0;

        // Predictor starts from the reset state.
        p_mode  = gvt_pkg::MODE_IDLE;
        p_op    = '0;
        p_count = '0;
        p_rx    = '0;
        p_ry    = '0;
        p_rw    = 11'd1;
        p_rh    = 10'd1;
        p_sx    = '0;
        p_sy    = '0;
        p_px    = '0;
        p_py    = '0;

        // Directed: idle reads, dropped and framed packets, edge rectangles.
        add_req(1'b1, 32'hffff_ffff);
        add_req(1'b0, 32'h0000_0000);
        add_req(1'b0, 32'hffff_ffff);
        add_noise_packet(gvt_pkg::OP_CLEAR_CACHE);
        add_noise_packet(gvt_pkg::OP_COPY_RECT);
        add_noise_packet(8'h3c);
        r = make_rect(5, 7, 1, 1);
        add_upload(r);
        add_readback(r);
        r = make_rect(1022, 511, 3, 1);
        add_upload(r);
        add_readback(r);

        // Random: uploads, readbacks, packets and stray reads.
        while (pending_q.size() < 260)
        begin
            c = $urandom_range(0, 99);
            if (c < 25)
                add_noise_packet(noise_op());
            else if (c < 30)
                add_req(1'b1, $urandom);
            else if (c < 62 || uploaded.size() == 0)
                add_upload(make_rect($urandom_range(0, 1023), $urandom_range(0, 511),
                                     $urandom_range(1, 6), $urandom_range(1, 4)),
                           $urandom_range(0, 19) == 0);
            else
                add_readback(uploaded[$urandom_range(0, uploaded.size() - 1)],
                             $urandom_range(0, 19) == 0);
        end

        // Full-size extreme: a whole column, then one more short readback.
        add_upload(make_rect($urandom_range(0, 1023), $urandom_range(0, 511), 1, 512), 1'b1);
        add_readback(uploaded[$urandom_range(0, uploaded.size() - 2)]);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_q.size() == 0 && !push);
        wait (expected_q.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/gvt_pkg.sv
hdl/gvt_fifo.sv
hdl/gvt_front.sv
hdl/gvt_back.sv
hdl/gpu_packet_vram_transfer_unit.sv
hdl/gvt_checker.sv
sim/tb.sv
